// File: rtl/g7c_pkg.sv
// Shared constants, mode codes and lookup tables for the G.711 codec.
`timescale 1ns / 1ps

package g7c_pkg;

    // conversion_mode codes
    localparam logic [2:0] MODE_PCM_TO_ALAW  = 3'd0;
    localparam logic [2:0] MODE_ALAW_TO_PCM  = 3'd1;
    localparam logic [2:0] MODE_PCM_TO_ULAW  = 3'd2;
    localparam logic [2:0] MODE_ULAW_TO_PCM  = 3'd3;
    localparam logic [2:0] MODE_ALAW_TO_ULAW = 3'd4;
    localparam logic [2:0] MODE_ULAW_TO_ALAW = 3'd5;

    localparam logic [6:0]  ALAW_XOR        = 7'h55;
    localparam logic [12:0] ALAW_ZERO_POINT = 13'h1000;
    localparam logic [7:0]  ALAW_ZERO_CODE  = 8'h2A;
    localparam logic [13:0] ULAW_BIAS       = 14'd33;
    localparam logic [13:0] ULAW_CLIP       = 14'd8159;
    localparam logic [13:0] ULAW_SMALL      = 14'd31;

    localparam logic [7:0] MU_TO_A_TAB [128] = '{
        8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd3,   8'd4,   8'd4,
        8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd7,   8'd8,   8'd8,
        8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,  8'd16,
        8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,  8'd24,
        8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd34,  8'd35,  8'd36,
        8'd37,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,  8'd44,
        8'd46,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
        8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
        8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,
        8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,
        8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,
        8'd89,  8'd90,  8'd91,  8'd92,  8'd93,  8'd94,  8'd95,  8'd96,
        8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103, 8'd104,
        8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112,
        8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120,
        8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128
    };

    localparam logic [7:0] A_TO_MU_TAB [128] = '{
        8'd1,   8'd3,   8'd5,   8'd7,   8'd9,   8'd11,  8'd13,  8'd15,
        8'd16,  8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,
        8'd24,  8'd25,  8'd26,  8'd27,  8'd28,  8'd29,  8'd30,  8'd31,
        8'd32,  8'd32,  8'd33,  8'd33,  8'd34,  8'd34,  8'd35,  8'd35,
        8'd36,  8'd37,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
        8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd48,  8'd49,  8'd49,
        8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,
        8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd64,
        8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,
        8'd73,  8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,  8'd79,
        8'd80,  8'd81,  8'd82,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,
        8'd88,  8'd89,  8'd90,  8'd91,  8'd92,  8'd93,  8'd94,  8'd95,
        8'd96,  8'd97,  8'd98,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103,
        8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111,
        8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
        8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127
    };

    function automatic logic [12:0] alaw_base(input logic [2:0] seg);
        logic [12:0] base;
        unique case (seg)
            3'd0: base = 13'd1;
            3'd1: base = 13'd33;
            3'd2: base = 13'd66;
            3'd3: base = 13'd132;
            3'd4: base = 13'd264;
            3'd5: base = 13'd528;
            3'd6: base = 13'd1056;
            3'd7: base = 13'd2112;
        endcase
        return base;
    endfunction

    function automatic logic [13:0] ulaw_base(input logic [2:0] seg);
        logic [13:0] base;
        unique case (seg)
            3'd0: base = 14'd0;
            3'd1: base = 14'd33;
            3'd2: base = 14'd99;
            3'd3: base = 14'd231;
            3'd4: base = 14'd495;
            3'd5: base = 14'd1023;
            3'd6: base = 14'd2079;
            3'd7: base = 14'd4191;
        endcase
        return base;
    endfunction

    // step is a power of two: log2 of it
    function automatic logic [3:0] alaw_shift(input logic [2:0] seg);
        return (seg == 3'd0) ? 4'd1 : {1'b0, seg};
    endfunction

    function automatic logic [3:0] ulaw_shift(input logic [2:0] seg);
        return {1'b0, seg} + 4'd1;
    endfunction

endpackage

// File: rtl/g711_companding_codec.sv
// Top level of the G.711 companding codec: stream ports, mode register, two-stage pipe.
`timescale 1ns / 1ps

// G.711 codec: each input transaction carries a 16-bit linear sample and a companded
// byte; the mode register (cfg_wr_data, 0..5) selects PCM->A-law, A-law->PCM,
// PCM->u-law, u-law->PCM, A-law->u-law or u-law->A-law, and each input yields one
// output transaction. Modes 6 and 7 give an all-zero result. The datapath is an input
// register, one level of conversion logic and an output register, so a result passes
// through the input register and then the output register before it is offered. A new
// transaction is accepted every cycle while the downstream side keeps up; the output
// register holds a stalled result while the input register still takes one more item.
// Change the mode only while idle.

module g711_companding_codec (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] pcm_in, [23:16] code_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [15:0] pcm_out, [23:16] code_out
);

    logic [2:0]  mode_reg;
    logic        in_valid_reg;
    logic [15:0] pcm_in_reg;
    logic [7:0]  code_in_reg;
    logic        out_valid_reg;
    logic [15:0] pcm_out_reg;
    logic [7:0]  code_out_reg;
    logic [15:0] pcm_out_next;
    logic [7:0]  code_out_next;
    logic        out_advance;

    logic [7:0]  alaw_code;
    logic [7:0]  ulaw_code;
    logic [15:0] alaw_pcm;
    logic [15:0] ulaw_pcm;
    logic [7:0]  a_to_u;
    logic [7:0]  u_to_a;

    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {code_out_reg, pcm_out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= g7c_pkg::MODE_PCM_TO_ALAW;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            pcm_in_reg  <= s_axis_tdata[15:0];
            code_in_reg <= s_axis_tdata[23:16];
        end
        if (in_valid_reg && out_advance)
        begin
            pcm_out_reg  <= pcm_out_next;
            code_out_reg <= code_out_next;
        end
    end

    g7c_alaw_enc u_alaw_enc (
        .pcm  (pcm_in_reg),
        .code (alaw_code)
    );

    g7c_ulaw_enc u_ulaw_enc (
        .pcm  (pcm_in_reg),
        .code (ulaw_code)
    );

    g7c_decode u_decode (
        .code     (code_in_reg),
        .alaw_pcm (alaw_pcm),
        .ulaw_pcm (ulaw_pcm)
    );

    g7c_transcode u_transcode (
        .code   (code_in_reg),
        .a_to_u (a_to_u),
        .u_to_a (u_to_a)
    );

    always_comb
    begin
        pcm_out_next  = 16'd0;
        code_out_next = 8'd0;
        unique case (mode_reg)
            g7c_pkg::MODE_PCM_TO_ALAW:  code_out_next = alaw_code;
            g7c_pkg::MODE_ALAW_TO_PCM:  pcm_out_next  = alaw_pcm;
            g7c_pkg::MODE_PCM_TO_ULAW:  code_out_next = ulaw_code;
            g7c_pkg::MODE_ULAW_TO_PCM:  pcm_out_next  = ulaw_pcm;
            g7c_pkg::MODE_ALAW_TO_ULAW: code_out_next = a_to_u;
            g7c_pkg::MODE_ULAW_TO_ALAW: code_out_next = u_to_a;
            default:
            begin
                pcm_out_next  = 16'd0;
                code_out_next = 8'd0;
            end
        endcase
    end

    // a result never carries both a sample and a code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pcm_out_reg == 16'd0 || code_out_reg == 8'd0))
        else $error("result has both pcm_out and code_out set");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted transaction lost at input register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_advance) |=> out_valid_reg)
        else $error("converted transaction lost at output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

endmodule

// File: rtl/g7c_alaw_enc.sv
// A-law encoder: 16-bit linear sample to companded byte.
`timescale 1ns / 1ps

module g7c_alaw_enc (
    input  logic [15:0] pcm,
    output logic [7:0]  code
);

    logic [12:0] v;
    logic [12:0] mag;
    logic [6:0]  low;

    always_comb
    begin
        v   = pcm[15:3];
        mag = v[12] ? (13'd0 - v) : v;
        priority if (mag[11]) low = {3'd7, mag[10:7]};
        else if (mag[10])     low = {3'd6, mag[9:6]};
        else if (mag[9])      low = {3'd5, mag[8:5]};
        else if (mag[8])      low = {3'd4, mag[7:4]};
        else if (mag[7])      low = {3'd3, mag[6:3]};
        else if (mag[6])      low = {3'd2, mag[5:2]};
        else                  low = {2'b00, mag[5:1]};
        // most negative truncated value has no positive twin
        if (v == g7c_pkg::ALAW_ZERO_POINT)
            code = g7c_pkg::ALAW_ZERO_CODE;
        else
            code = {~v[12], low ^ g7c_pkg::ALAW_XOR};
    end

endmodule

// File: rtl/g7c_ulaw_enc.sv
// u-law encoder: 16-bit linear sample to companded byte.
`timescale 1ns / 1ps

module g7c_ulaw_enc (
    input  logic [15:0] pcm,
    output logic [7:0]  code
);

    logic [13:0] v;
    logic [13:0] mag;
    logic [13:0] biased;
    logic [4:0]  small_m1;
    logic [6:0]  low;

    always_comb
    begin
        v        = pcm[15:2];
        mag      = v[13] ? (14'd0 - v) : v;
        biased   = mag + g7c_pkg::ULAW_BIAS;
        small_m1 = mag[4:0] - 5'd1;
        priority if (mag < g7c_pkg::ULAW_SMALL)
            low = (mag == 14'd0) ? 7'd0 : {3'd0, small_m1[4:1] + 4'd1};
        else if (mag >= g7c_pkg::ULAW_CLIP) low = 7'h7F;
        else if (biased[12])                low = {3'd7, biased[11:8]};
        else if (biased[11])                low = {3'd6, biased[10:7]};
        else if (biased[10])                low = {3'd5, biased[9:6]};
        else if (biased[9])                 low = {3'd4, biased[8:5]};
        else if (biased[8])                 low = {3'd3, biased[7:4]};
        else if (biased[7])                 low = {3'd2, biased[6:3]};
        else                                low = {3'd1, biased[5:2]};
        code = ~{v[13], low};
    end

endmodule

// File: rtl/g7c_decode.sv
// A-law and u-law decoders: companded byte to 16-bit linear sample.
`timescale 1ns / 1ps

module g7c_decode (
    input  logic [7:0]  code,
    output logic [15:0] alaw_pcm,
    output logic [15:0] ulaw_pcm
);

    logic [6:0]  t;
    logic [12:0] a_mag;
    logic [7:0]  u;
    logic [13:0] u_mag;

    always_comb
    begin
        t        = code[6:0] ^ g7c_pkg::ALAW_XOR;
        a_mag    = g7c_pkg::alaw_base(t[6:4])
                 + (13'(t[3:0]) << g7c_pkg::alaw_shift(t[6:4]));
        alaw_pcm = {(code[7] ? a_mag : (13'd0 - a_mag)), 3'b000};

        u        = ~code;
        u_mag    = g7c_pkg::ulaw_base(u[6:4])
                 + (14'(u[3:0]) << g7c_pkg::ulaw_shift(u[6:4]));
        ulaw_pcm = {(u[7] ? (14'd0 - u_mag) : u_mag), 2'b00};
    end

endmodule

// File: rtl/g7c_transcode.sv
// A-law <-> u-law transcoding through the two fixed tables.
`timescale 1ns / 1ps

module g7c_transcode (
    input  logic [7:0] code,
    output logic [7:0] a_to_u,
    output logic [7:0] u_to_a
);

    logic [7:0] mu_val;
    logic [7:0] a_val;

    always_comb
    begin
        mu_val = g7c_pkg::A_TO_MU_TAB[code[6:0] ^ g7c_pkg::ALAW_XOR];
        a_to_u = {code[7], ~mu_val[6:0]};
        a_val  = g7c_pkg::MU_TO_A_TAB[~code[6:0]] - 8'd1;
        u_to_a = {code[7], a_val[6:0] ^ g7c_pkg::ALAW_XOR};
    end

endmodule
